// File: src/i2cmbc_pkg.sv
package i2cmbc_pkg;

   localparam int TickWidth  = 16;
   localparam int PollWidth  = 8;
   localparam int DelayWidth = 18;
   localparam int CsrIdxWidth = 2;

   localparam logic [TickWidth-1:0] TicksPerUnitReset = 16'd100;
   localparam logic [PollWidth-1:0] AckPollLimitReset = 8'd250;

   // register indexes on the csr port
   localparam logic [CsrIdxWidth-1:0] CSR_TICKS_PER_UNIT = 2'd0;
   localparam logic [CsrIdxWidth-1:0] CSR_ACK_POLL_LIMIT = 2'd1;

   // command codes
   localparam logic [2:0] OP_NONE     = 3'd0;
   localparam logic [2:0] OP_START    = 3'd1;
   localparam logic [2:0] OP_STOP     = 3'd2;
   localparam logic [2:0] OP_WRITE    = 3'd3;
   localparam logic [2:0] OP_READ     = 3'd4;
   localparam logic [2:0] OP_WAIT_ACK = 3'd5;

   typedef struct packed {
      logic       scl_level;
      logic       sda_level;
      logic       sda_enable;
      logic       busy_res;
      logic       done_res;
      logic [7:0] rx_byte;
      logic       no_ack;
      logic       rejected;
   } result_type;

endpackage

// File: src/i2cmbc_seq.sv
module i2cmbc_seq (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  accept,
   input  logic [2:0]                            operation,
   input  logic [7:0]                            tx_byte,
   input  logic                                  send_ack,
   input  logic                                  sda_in,
   input  logic [i2cmbc_pkg::TickWidth-1:0]      ticks_per_unit,
   input  logic [i2cmbc_pkg::PollWidth-1:0]      ack_poll_limit,
   output i2cmbc_pkg::result_type                result
);

   typedef enum logic [3:0] {
      PH_IDLE, PH_ST0, PH_ST1, PH_SP0, PH_SP1, PH_WB0, PH_WB1, PH_WB2,
      PH_RB0, PH_RB1, PH_AK0, PH_AK1, PH_WA0, PH_WA1, PH_WA2
   } phase_type;

   phase_type                               phase_ff, phase_in;
   logic [i2cmbc_pkg::DelayWidth-1:0]       delay_ff, delay_in;
   logic [3:0]                              bit_count_ff, bit_count_in;
   logic [7:0]                              shift_ff, shift_in;
   logic                                    ack_choice_ff, ack_choice_in;
   logic [i2cmbc_pkg::PollWidth-1:0]        poll_ff, poll_in;
   logic                                    scl_ff, scl_in;
   logic                                    sda_drv_ff, sda_drv_in;
   logic                                    oe_ff, oe_in;
   logic [7:0]                              rx_ff, rx_in;
   logic                                    nack_ff, nack_in;
   logic                                    done;
   logic                                    rej;

   logic [i2cmbc_pkg::TickWidth-1:0]        tick;
   logic [i2cmbc_pkg::DelayWidth-1:0]       delay_1u, delay_2u, delay_4u;
   logic [3:0]                              bit_next;

   // a zero unit length counts as one tick
   assign tick     = (ticks_per_unit == '0) ? i2cmbc_pkg::TickWidth'(1) : ticks_per_unit;
   assign delay_1u = {2'b00, tick};
   assign delay_2u = {1'b0, tick, 1'b0};
   assign delay_4u = {tick, 2'b00};
   assign bit_next = bit_count_ff + 4'd1;

   always_comb begin
      phase_in      = phase_ff;
      delay_in      = delay_ff;
      bit_count_in  = bit_count_ff;
      shift_in      = shift_ff;
      ack_choice_in = ack_choice_ff;
      poll_in       = poll_ff;
      scl_in        = scl_ff;
      sda_drv_in    = sda_drv_ff;
      oe_in         = oe_ff;
      rx_in         = rx_ff;
      nack_in       = nack_ff;
      done          = 1'b0;
      rej           = 1'b0;

      if (phase_ff == PH_IDLE) begin
         unique case (operation)
            i2cmbc_pkg::OP_START: begin
               oe_in = 1'b1; sda_drv_in = 1'b1; scl_in = 1'b1;
               phase_in = PH_ST0; delay_in = delay_4u;
            end
            i2cmbc_pkg::OP_STOP: begin
               oe_in = 1'b1; scl_in = 1'b0; sda_drv_in = 1'b0;
               phase_in = PH_SP0; delay_in = delay_4u;
            end
            i2cmbc_pkg::OP_WRITE: begin
               oe_in = 1'b1; scl_in = 1'b0;
               sda_drv_in = tx_byte[7]; shift_in = {tx_byte[6:0], 1'b0};
               bit_count_in = 4'd0;
               phase_in = PH_WB0; delay_in = delay_2u;
            end
            i2cmbc_pkg::OP_READ: begin
               oe_in = 1'b0; scl_in = 1'b0;
               shift_in = 8'd0; bit_count_in = 4'd0; ack_choice_in = send_ack;
               phase_in = PH_RB0; delay_in = delay_2u;
            end
            i2cmbc_pkg::OP_WAIT_ACK: begin
               sda_drv_in = 1'b1; oe_in = 1'b0; nack_in = 1'b0;
               phase_in = PH_WA0; delay_in = delay_1u;
            end
            default: ;
         endcase
      end else begin
         rej = (operation != i2cmbc_pkg::OP_NONE);
         if (phase_ff == PH_WA2) begin
            if (!sda_in) begin
               scl_in = 1'b0; phase_in = PH_IDLE; done = 1'b1;
            end else if (poll_ff >= ack_poll_limit) begin
               // ack timeout: flag it and run a stop
               nack_in = 1'b1;
               oe_in = 1'b1; scl_in = 1'b0; sda_drv_in = 1'b0;
               phase_in = PH_SP0; delay_in = delay_4u;
            end else begin
               poll_in = poll_ff + 1'b1;
            end
         end else if (delay_ff > i2cmbc_pkg::DelayWidth'(1)) begin
            delay_in = delay_ff - 1'b1;
         end else begin
            unique case (phase_ff)
               PH_ST0: begin
                  sda_drv_in = 1'b0; phase_in = PH_ST1; delay_in = delay_4u;
               end
               PH_ST1: begin
                  scl_in = 1'b0; done = 1'b1;
               end
               PH_SP0: begin
                  scl_in = 1'b1; sda_drv_in = 1'b1; phase_in = PH_SP1; delay_in = delay_4u;
               end
               PH_SP1: done = 1'b1;
               PH_WB0: begin
                  scl_in = 1'b1; phase_in = PH_WB1; delay_in = delay_2u;
               end
               PH_WB1: begin
                  scl_in = 1'b0; phase_in = PH_WB2; delay_in = delay_2u;
               end
               PH_WB2: begin
                  bit_count_in = bit_next;
                  if (bit_next < 4'd8) begin
                     sda_drv_in = shift_ff[7]; shift_in = {shift_ff[6:0], 1'b0};
                     phase_in = PH_WB0; delay_in = delay_2u;
                  end else begin
                     done = 1'b1;
                  end
               end
               PH_RB0: begin
                  scl_in = 1'b1; shift_in = {shift_ff[6:0], sda_in};
                  phase_in = PH_RB1; delay_in = delay_1u;
               end
               PH_RB1: begin
                  bit_count_in = bit_next; scl_in = 1'b0; delay_in = delay_2u;
                  if (bit_next < 4'd8) begin
                     phase_in = PH_RB0;
                  end else begin
                     oe_in = 1'b1; sda_drv_in = ~ack_choice_ff; phase_in = PH_AK0;
                  end
               end
               PH_AK0: begin
                  scl_in = 1'b1; phase_in = PH_AK1; delay_in = delay_2u;
               end
               PH_AK1: begin
                  scl_in = 1'b0; rx_in = shift_ff; done = 1'b1;
               end
               PH_WA0: begin
                  scl_in = 1'b1; phase_in = PH_WA1; delay_in = delay_1u;
               end
               PH_WA1: begin
                  poll_in = '0; phase_in = PH_WA2; delay_in = '0;
               end
               default: done = 1'b1;
            endcase
            if (done) begin
               phase_in = PH_IDLE; delay_in = '0;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff      <= PH_IDLE;
         delay_ff      <= '0;
         bit_count_ff  <= '0;
         shift_ff      <= '0;
         ack_choice_ff <= 1'b0;
         poll_ff       <= '0;
         scl_ff        <= 1'b1;
         sda_drv_ff    <= 1'b1;
         oe_ff         <= 1'b1;
         rx_ff         <= '0;
         nack_ff       <= 1'b0;
      end else if (accept) begin
         phase_ff      <= phase_in;
         delay_ff      <= delay_in;
         bit_count_ff  <= bit_count_in;
         shift_ff      <= shift_in;
         ack_choice_ff <= ack_choice_in;
         poll_ff       <= poll_in;
         scl_ff        <= scl_in;
         sda_drv_ff    <= sda_drv_in;
         oe_ff         <= oe_in;
         rx_ff         <= rx_in;
         nack_ff       <= nack_in;
      end
   end

   always_comb begin
      result.scl_level  = scl_in;
      result.sda_level  = sda_drv_in;
      result.sda_enable = oe_in;
      result.busy_res   = (phase_in != PH_IDLE);
      result.done_res   = done;
      result.rx_byte    = rx_in;
      result.no_ack     = nack_in;
      result.rejected   = rej;
   end

endmodule

// File: src/i2c_master_byte_controller.sv
// channel | direction | handshake           | payload
// req     | in        | req_valid/req_stall | operation, tx_byte, send_ack, sda_in
// rsp     | out       | rsp_valid/rsp_stall | scl/sda levels, sda_enable, status, rx_byte
// csr     | in        | csr_valid/csr_ready | csr_index, csr_wdata
//
// one word per cycle while req_stall is low: each word is one bus tick, evaluated
// in a single pass and captured in the result register on the edge it is accepted.
// req_stall rises only while a result is held and rsp_stall is high.
// reset (synchronous) idles the bus with scl, sda and sda_enable high.
// csr is always ready; writes are meant for idle periods.
module i2c_master_byte_controller (
   input  logic                                   clock,
   input  logic                                   reset,
   input  logic                                   req_valid,
   output logic                                   req_stall,
   input  logic [2:0]                             req_operation,
   input  logic [7:0]                             req_tx_byte,
   input  logic                                   req_send_ack,
   input  logic                                   req_sda_in,
   output logic                                   rsp_valid,
   input  logic                                   rsp_stall,
   output logic                                   rsp_scl_level,
   output logic                                   rsp_sda_level,
   output logic                                   rsp_sda_enable,
   output logic                                   rsp_busy_res,
   output logic                                   rsp_done_res,
   output logic [7:0]                             rsp_rx_byte,
   output logic                                   rsp_no_ack,
   output logic                                   rsp_rejected,
   input  logic                                   csr_valid,
   output logic                                   csr_ready,
   input  logic [i2cmbc_pkg::CsrIdxWidth-1:0]     csr_index,
   input  logic [i2cmbc_pkg::TickWidth-1:0]       csr_wdata
);

   logic [i2cmbc_pkg::TickWidth-1:0] ticks_per_unit_ff;
   logic [i2cmbc_pkg::PollWidth-1:0] ack_poll_limit_ff;
   logic                             rsp_valid_ff;
   i2cmbc_pkg::result_type           result;
   i2cmbc_pkg::result_type           rsp_ff;
   logic                             accept;

   assign csr_ready = 1'b1;
   assign req_stall = rsp_valid_ff & rsp_stall;
   assign accept    = req_valid & ~req_stall;

   always_ff @(posedge clock) begin
      if (reset) begin
         ticks_per_unit_ff <= i2cmbc_pkg::TicksPerUnitReset;
         ack_poll_limit_ff <= i2cmbc_pkg::AckPollLimitReset;
      end else if (csr_valid) begin
         if (csr_index == i2cmbc_pkg::CSR_TICKS_PER_UNIT) begin
            ticks_per_unit_ff <= csr_wdata;
         end else if (csr_index == i2cmbc_pkg::CSR_ACK_POLL_LIMIT) begin
            ack_poll_limit_ff <= csr_wdata[i2cmbc_pkg::PollWidth-1:0];
         end
      end
   end

   i2cmbc_seq u_seq (
      .clock          (clock),
      .reset          (reset),
      .accept         (accept),
      .operation      (req_operation),
      .tx_byte        (req_tx_byte),
      .send_ack       (req_send_ack),
      .sda_in         (req_sda_in),
      .ticks_per_unit (ticks_per_unit_ff),
      .ack_poll_limit (ack_poll_limit_ff),
      .result         (result)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (accept) begin
         rsp_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         rsp_ff <= result;
      end
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_scl_level  = rsp_ff.scl_level;
   assign rsp_sda_level  = rsp_ff.sda_level;
   assign rsp_sda_enable = rsp_ff.sda_enable;
   assign rsp_busy_res   = rsp_ff.busy_res;
   assign rsp_done_res   = rsp_ff.done_res;
   assign rsp_rx_byte    = rsp_ff.rx_byte;
   assign rsp_no_ack     = rsp_ff.no_ack;
   assign rsp_rejected   = rsp_ff.rejected;

endmodule

// File: src/i2cmbc_checker.sv
module i2cmbc_checker (
   input logic       clock,
   input logic       reset,
   input logic       req_stall,
   input logic       rsp_valid,
   input logic       rsp_stall,
   input logic       rsp_busy_res,
   input logic       rsp_done_res,
   input logic [7:0] rsp_rx_byte
);

   // a finished sequence leaves the controller idle
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_done_res |-> !rsp_busy_res)
      else $error("done word still reports busy");

   // input only backs up behind a held result
   assert property (@(posedge clock) disable iff (reset)
      req_stall |-> rsp_valid && rsp_stall)
      else $error("input stalled without a held result");

   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_rx_byte) && $stable(rsp_done_res))
      else $error("stalled result word changed");

endmodule

bind i2c_master_byte_controller i2cmbc_checker u_i2cmbc_checker (
   .clock        (clock),
   .reset        (reset),
   .req_stall    (req_stall),
   .rsp_valid    (rsp_valid),
   .rsp_stall    (rsp_stall),
   .rsp_busy_res (rsp_busy_res),
   .rsp_done_res (rsp_done_res),
   .rsp_rx_byte  (rsp_rx_byte)
);

// File: tb/tb.sv
`timescale 1ns / 1ps

module tb;

   localparam logic [2:0] OP_SPARE_LO = 3'd6;
   localparam logic [2:0] OP_SPARE_HI = 3'd7;
   localparam logic [i2cmbc_pkg::CsrIdxWidth-1:0] CSR_SPARE_LO = 2'd2;
   localparam logic [i2cmbc_pkg::CsrIdxWidth-1:0] CSR_SPARE_HI = 2'd3;
   localparam int HOLD_OFF_CYCLES = 120;

   typedef enum logic [4:0] {
      BUS_IDLE, START_HOLD, START_LOW, STOP_LOW, STOP_HIGH,
      WR_SETUP, WR_HIGH, WR_LOW, RD_LOW, RD_HIGH,
      ACK_LOW, ACK_HIGH, WAIT_RELEASE, WAIT_HIGH, WAIT_POLL
   } bus_phase_type;

   typedef enum {MIX_PLAIN, MIX_BACKPRESSURE, MIX_STREAM} traffic_mix_type;

   typedef struct {
      bit                                     is_reg;
      logic [i2cmbc_pkg::CsrIdxWidth-1:0]     reg_idx;
      logic [i2cmbc_pkg::TickWidth-1:0]       reg_data;
      logic [2:0]                             op;
      logic [7:0]                             tx;
      logic                                   ack;
      logic                                   sda;
      bit                                     drain;
      bit                                     typed;
      i2cmbc_pkg::result_type                 want;
   } probe_row_type;

   logic clock;
   logic reset;
   logic req_valid;
   logic req_stall;
   logic [2:0] req_operation;
   logic [7:0] req_tx_byte;
   logic req_send_ack;
   logic req_sda_in;
   logic rsp_valid;
   logic rsp_stall;
   logic rsp_scl_level;
   logic rsp_sda_level;
   logic rsp_sda_enable;
   logic rsp_busy_res;
   logic rsp_done_res;
   logic [7:0] rsp_rx_byte;
   logic rsp_no_ack;
   logic rsp_rejected;
   logic csr_valid;
   logic csr_ready;
   logic [i2cmbc_pkg::CsrIdxWidth-1:0] csr_index;
   logic [i2cmbc_pkg::TickWidth-1:0] csr_wdata;

   i2c_master_byte_controller dut (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_stall      (req_stall),
      .req_operation  (req_operation),
      .req_tx_byte    (req_tx_byte),
      .req_send_ack   (req_send_ack),
      .req_sda_in     (req_sda_in),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_scl_level  (rsp_scl_level),
      .rsp_sda_level  (rsp_sda_level),
      .rsp_sda_enable (rsp_sda_enable),
      .rsp_busy_res   (rsp_busy_res),
      .rsp_done_res   (rsp_done_res),
      .rsp_rx_byte    (rsp_rx_byte),
      .rsp_no_ack     (rsp_no_ack),
      .rsp_rejected   (rsp_rejected),
      .csr_valid      (csr_valid),
      .csr_ready      (csr_ready),
      .csr_index      (csr_index),
      .csr_wdata      (csr_wdata)
   );

   // bus sequencer mirror
   bus_phase_type bus_phase;
   logic [i2cmbc_pkg::DelayWidth-1:0] ticks_left;
   logic [3:0] bits_done;
   logic [7:0] shreg;
   logic ack_choice_q;
   logic [i2cmbc_pkg::PollWidth-1:0] polls;
   logic scl_q, sda_q, sda_oe_q;
   logic [7:0] rx_q;
   logic nack_q;
   logic [i2cmbc_pkg::TickWidth-1:0] unit_ticks_cfg;
   logic [i2cmbc_pkg::PollWidth-1:0] poll_limit_cfg;

   i2cmbc_pkg::result_type expected_q[$];
   probe_row_type probe_rows[$];
   int mismatches = 0;
   int words_sent = 0;
   int acks_after = 0;
   bit quiet_sender = 1'b0;
   bit quiet_receiver = 1'b0;
   bit hold_request = 1'b0;

   initial clock = 1'b0;
   always #10 clock = ~clock;

   initial begin
      #10_000_000;
      $display("*** FAILED ***");
      $finish;
   end

   function automatic void reset_model();
      bus_phase = BUS_IDLE;
      ticks_left = '0;
      bits_done = '0;
      shreg = '0;
      ack_choice_q = 1'b0;
      polls = '0;
      scl_q = 1'b1;
      sda_q = 1'b1;
      sda_oe_q = 1'b1;
      rx_q = '0;
      nack_q = 1'b0;
      unit_ticks_cfg = i2cmbc_pkg::TicksPerUnitReset;
      poll_limit_cfg = i2cmbc_pkg::AckPollLimitReset;
   endfunction

   function automatic void arm_delay(input int units);
      int t;
      t = (unit_ticks_cfg == 0) ? 1 : int'(unit_ticks_cfg);
      ticks_left = i2cmbc_pkg::DelayWidth'(units * t);
   endfunction

   function automatic void shift_out_bit();
      sda_q = shreg[7];
      shreg = {shreg[6:0], 1'b0};
   endfunction

   function automatic void enter_stop();
      sda_oe_q = 1'b1;
      scl_q = 1'b0;
      sda_q = 1'b0;
      bus_phase = STOP_LOW;
      arm_delay(4);
   endfunction

   // current stage has timed out, returns 1 when the command is over
   function automatic bit stage_expired(input logic sda);
      bit ended;
      ended = 1'b0;
      case (bus_phase)
         START_HOLD: begin
            sda_q = 1'b0;
            bus_phase = START_LOW;
            arm_delay(4);
         end
         START_LOW: begin
            scl_q = 1'b0;
            ended = 1'b1;
         end
         STOP_LOW: begin
            scl_q = 1'b1;
            sda_q = 1'b1;
            bus_phase = STOP_HIGH;
            arm_delay(4);
         end
         WR_SETUP: begin
            scl_q = 1'b1;
            bus_phase = WR_HIGH;
            arm_delay(2);
         end
         WR_HIGH: begin
            scl_q = 1'b0;
            bus_phase = WR_LOW;
            arm_delay(2);
         end
         WR_LOW: begin
            bits_done = bits_done + 1'b1;
            if (bits_done < 8) begin
               shift_out_bit();
               bus_phase = WR_SETUP;
               arm_delay(2);
            end else begin
               ended = 1'b1;
            end
         end
         RD_LOW: begin
            scl_q = 1'b1;
            shreg = {shreg[6:0], sda};
            bus_phase = RD_HIGH;
            arm_delay(1);
         end
         RD_HIGH: begin
            bits_done = bits_done + 1'b1;
            scl_q = 1'b0;
            if (bits_done < 8) begin
               bus_phase = RD_LOW;
               arm_delay(2);
            end else begin
               sda_oe_q = 1'b1;
               sda_q = ~ack_choice_q;
               bus_phase = ACK_LOW;
               arm_delay(2);
            end
         end
         ACK_LOW: begin
            scl_q = 1'b1;
            bus_phase = ACK_HIGH;
            arm_delay(2);
         end
         ACK_HIGH: begin
            scl_q = 1'b0;
            rx_q = shreg;
            ended = 1'b1;
         end
         WAIT_RELEASE: begin
            scl_q = 1'b1;
            bus_phase = WAIT_HIGH;
            arm_delay(1);
         end
         WAIT_HIGH: begin
            polls = '0;
            bus_phase = WAIT_POLL;
            ticks_left = '0;
         end
         default: ended = 1'b1;
      endcase
      return ended;
   endfunction

   function automatic void open_command(input logic [2:0] op, input logic [7:0] tx,
                                        input logic ack);
      case (op)
         i2cmbc_pkg::OP_START: begin
            sda_oe_q = 1'b1;
            sda_q = 1'b1;
            scl_q = 1'b1;
            bus_phase = START_HOLD;
            arm_delay(4);
         end
         i2cmbc_pkg::OP_STOP: enter_stop();
         i2cmbc_pkg::OP_WRITE: begin
            sda_oe_q = 1'b1;
            scl_q = 1'b0;
            shreg = tx;
            bits_done = '0;
            shift_out_bit();
            bus_phase = WR_SETUP;
            arm_delay(2);
         end
         i2cmbc_pkg::OP_READ: begin
            sda_oe_q = 1'b0;
            scl_q = 1'b0;
            shreg = '0;
            bits_done = '0;
            ack_choice_q = ack;
            bus_phase = RD_LOW;
            arm_delay(2);
         end
         default: begin
            sda_q = 1'b1;
            sda_oe_q = 1'b0;
            nack_q = 1'b0;
            bus_phase = WAIT_RELEASE;
            arm_delay(1);
         end
      endcase
   endfunction

   function automatic i2cmbc_pkg::result_type bus_tick(input logic [2:0] op,
                                                       input logic [7:0] tx,
                                                       input logic ack, input logic sda);
      i2cmbc_pkg::result_type r;
      logic fin;
      logic rej;
      fin = 1'b0;
      rej = 1'b0;
      if (bus_phase == BUS_IDLE) begin
         if (op >= i2cmbc_pkg::OP_START && op <= i2cmbc_pkg::OP_WAIT_ACK)
            open_command(op, tx, ack);
      end else begin
         rej = (op != i2cmbc_pkg::OP_NONE);
         if (bus_phase == WAIT_POLL) begin
            if (!sda) begin
               scl_q = 1'b0;
               bus_phase = BUS_IDLE;
               fin = 1'b1;
            end else if (polls >= poll_limit_cfg) begin
               nack_q = 1'b1;
               enter_stop();
            end else begin
               polls = polls + 1'b1;
            end
         end else if (ticks_left > 1) begin
            ticks_left = ticks_left - 1'b1;
         end else if (stage_expired(sda)) begin
            bus_phase = BUS_IDLE;
            ticks_left = '0;
            fin = 1'b1;
         end
      end
      r.scl_level = scl_q;
      r.sda_level = sda_q;
      r.sda_enable = sda_oe_q;
      r.busy_res = (bus_phase != BUS_IDLE);
      r.done_res = fin;
      r.rx_byte = rx_q;
      r.no_ack = nack_q;
      r.rejected = rej;
      return r;
   endfunction

   function automatic i2cmbc_pkg::result_type levels(input logic scl, input logic sda,
                                                     input logic en, input logic busy,
                                                     input logic done,
                                                     input logic [7:0] rx, input logic nack,
                                                     input logic rej);
      i2cmbc_pkg::result_type r;
      r.scl_level = scl;
      r.sda_level = sda;
      r.sda_enable = en;
      r.busy_res = busy;
      r.done_res = done;
      r.rx_byte = rx;
      r.no_ack = nack;
      r.rejected = rej;
      return r;
   endfunction

   function automatic int pick_gap(input bit quiet);
      int roll;
      if (quiet) return 0;
      roll = $urandom_range(0, 99);
      if (roll < 65) return 0;
      if (roll < 93) return $urandom_range(1, 3);
      return $urandom_range(4, 30);
   endfunction

   function automatic void add_word(input logic [2:0] op, input logic [7:0] tx,
                                    input logic ack, input logic sda, input bit drain,
                                    input bit typed = 1'b0,
                                    input i2cmbc_pkg::result_type want = '0);
      probe_row_type row;
      row.is_reg = 1'b0;
      row.reg_idx = '0;
      row.reg_data = '0;
      row.op = op;
      row.tx = tx;
      row.ack = ack;
      row.sda = sda;
      row.drain = drain;
      row.typed = typed;
      row.want = want;
      probe_rows.push_back(row);
   endfunction

   function automatic void add_reg(input logic [i2cmbc_pkg::CsrIdxWidth-1:0] idx,
                                   input logic [i2cmbc_pkg::TickWidth-1:0] data);
      probe_row_type row;
      row.is_reg = 1'b1;
      row.reg_idx = idx;
      row.reg_data = data;
      row.op = i2cmbc_pkg::OP_NONE;
      row.tx = '0;
      row.ack = 1'b0;
      row.sda = 1'b0;
      row.drain = 1'b0;
      row.typed = 1'b0;
      row.want = '0;
      probe_rows.push_back(row);
   endfunction

   function automatic void check_field(input string name, input int want, input int got);
      if (want != got) begin
         $display("%0t: %s mismatch, expected %0d, got %0d", $time, name, want, got);
         mismatches++;
      end
   endfunction

   always @(posedge clock) begin
      i2cmbc_pkg::result_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (expected_q.size() == 0) begin
            $display("%0t: unexpected word, expected nothing, got scl %0b sda %0b rx %0h",
                     $time, rsp_scl_level, rsp_sda_level, rsp_rx_byte);
            mismatches++;
         end else begin
            want = expected_q.pop_front();
            check_field("scl_level", want.scl_level, rsp_scl_level);
            check_field("sda_level", want.sda_level, rsp_sda_level);
            check_field("sda_enable", want.sda_enable, rsp_sda_enable);
            check_field("busy_res", want.busy_res, rsp_busy_res);
            check_field("done_res", want.done_res, rsp_done_res);
            check_field("rx_byte", want.rx_byte, rsp_rx_byte);
            check_field("no_ack", want.no_ack, rsp_no_ack);
            check_field("rejected", want.rejected, rsp_rejected);
         end
      end
   end

   // receiver: random stalls, plus one long hold-off on request
   initial begin
      int span;
      rsp_stall <= 1'b0;
      forever begin
         @(negedge clock);
         if (hold_request) begin
            hold_request = 1'b0;
            rsp_stall <= 1'b1;
            repeat (HOLD_OFF_CYCLES) @(negedge clock);
            rsp_stall <= 1'b0;
         end else begin
            span = pick_gap(quiet_receiver);
            if (span > 0) begin
               rsp_stall <= 1'b1;
               repeat (span) @(negedge clock);
            end
            rsp_stall <= 1'b0;
         end
      end
   end

   // called at a falling edge, returns at the falling edge after the word is taken
   task automatic send_word(input logic [2:0] op, input logic [7:0] tx, input logic ack,
                            input logic sda, input bit typed = 1'b0,
                            input i2cmbc_pkg::result_type typed_res = '0);
      int gap;
      i2cmbc_pkg::result_type predicted;
      gap = pick_gap(quiet_sender);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      if (!(bus_phase == BUS_IDLE &&
            !(op >= i2cmbc_pkg::OP_START && op <= i2cmbc_pkg::OP_WAIT_ACK)))
         words_sent++;
      predicted = bus_tick(op, tx, ack, sda);
      expected_q.push_back(typed ? typed_res : predicted);
      req_valid <= 1'b1;
      req_operation <= op;
      req_tx_byte <= tx;
      req_send_ack <= ack;
      req_sda_in <= sda;
      do @(posedge clock); while (req_stall);
      @(negedge clock);
   endtask

   task automatic wait_settled();
      req_valid <= 1'b0;
      while (expected_q.size() != 0) @(negedge clock);
      repeat (4) @(negedge clock);
   endtask

   task automatic write_reg(input logic [i2cmbc_pkg::CsrIdxWidth-1:0] idx,
                            input logic [i2cmbc_pkg::TickWidth-1:0] data);
      wait_settled();
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      do @(posedge clock); while (!csr_ready);
      if (idx == i2cmbc_pkg::CSR_TICKS_PER_UNIT) unit_ticks_cfg = data;
      else if (idx == i2cmbc_pkg::CSR_ACK_POLL_LIMIT)
         poll_limit_cfg = data[i2cmbc_pkg::PollWidth-1:0];
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   // clock idle ticks, with stray codes now and then when noisy, until the current command finishes
   task automatic drain_bus(input bit noisy, input bit fixed, input logic level);
      logic [2:0] op;
      logic sda;
      while (bus_phase != BUS_IDLE) begin
         op = (noisy && $urandom_range(0, 19) == 0) ? 3'($urandom_range(1, 7))
                                                     : i2cmbc_pkg::OP_NONE;
         if (fixed) begin
            sda = level;
         end else if (bus_phase == WAIT_POLL) begin
            sda = (acks_after == 0) ? 1'b0 : 1'b1;
            if (acks_after > 0) acks_after--;
         end else begin
            sda = 1'($urandom_range(0, 1));
         end
         send_word(op, 8'($urandom), 1'($urandom_range(0, 1)), sda);
      end
   endtask

   task automatic issue(input logic [2:0] op, input logic [7:0] tx, input logic ack);
      send_word(op, tx, ack, 1'($urandom_range(0, 1)));
      drain_bus(1'b1, 1'b0, 1'b0);
   endtask

   task automatic ack_from_target();
      acks_after = ($urandom_range(0, 99) < 80) ? $urandom_range(0, 6) : -1;
      issue(i2cmbc_pkg::OP_WAIT_ACK, 8'($urandom), 1'($urandom_range(0, 1)));
   endtask

   // start, address, ack, up to three data bytes, stop; start or stop sometimes missing
   task automatic run_transfer();
      int n;
      n = $urandom_range(0, 3);
      if ($urandom_range(0, 9) != 0)
         issue(i2cmbc_pkg::OP_START, 8'($urandom), 1'($urandom_range(0, 1)));
      issue(i2cmbc_pkg::OP_WRITE, 8'($urandom), 1'($urandom_range(0, 1)));
      ack_from_target();
      repeat (n) begin
         if (nack_q) break;
         if ($urandom_range(0, 1)) begin
            issue(i2cmbc_pkg::OP_WRITE, 8'($urandom), 1'($urandom_range(0, 1)));
            ack_from_target();
         end else begin
            issue(i2cmbc_pkg::OP_READ, 8'($urandom), 1'($urandom_range(0, 1)));
         end
      end
      if ($urandom_range(0, 9) != 0)
         issue(i2cmbc_pkg::OP_STOP, 8'($urandom), 1'($urandom_range(0, 1)));
   endtask

   task automatic run_phase(input logic [i2cmbc_pkg::TickWidth-1:0] ticks,
                            input logic [i2cmbc_pkg::PollWidth-1:0] limit,
                            input int quota, input traffic_mix_type mix);
      int stop_at;
      write_reg(i2cmbc_pkg::CSR_TICKS_PER_UNIT, ticks);
      write_reg(i2cmbc_pkg::CSR_ACK_POLL_LIMIT, {8'h00, limit});
      quiet_sender = (mix != MIX_PLAIN);
      quiet_receiver = (mix == MIX_STREAM);
      if (mix == MIX_BACKPRESSURE) hold_request = 1'b1;
      stop_at = words_sent + quota;
      while (words_sent < stop_at) begin
         if ($urandom_range(0, 5) == 0) begin
            send_word(3'($urandom_range(0, 7)), 8'($urandom), 1'($urandom_range(0, 1)),
                      1'($urandom_range(0, 1)));
            drain_bus(1'b1, 1'b0, 1'b0);
         end else begin
            run_transfer();
         end
         if ($urandom_range(0, 7) == 0) wait_settled();
      end
      quiet_sender = 1'b0;
      quiet_receiver = 1'b0;
   endtask

   initial begin
      reset <= 1'b1;
      req_valid <= 1'b0;
      req_operation <= i2cmbc_pkg::OP_NONE;
      req_tx_byte <= '0;
      req_send_ack <= 1'b0;
      req_sda_in <= 1'b0;
      csr_valid <= 1'b0;
      csr_index <= i2cmbc_pkg::CSR_TICKS_PER_UNIT;
      csr_wdata <= '0;
      reset_model();

      // bus released after reset, idle codes do nothing
      add_word(i2cmbc_pkg::OP_NONE, 8'h00, 1'b0, 1'b0, 1'b0, 1'b1,
               levels(1'b1, 1'b1, 1'b1, 1'b0, 1'b0, 8'h00, 1'b0, 1'b0));
      add_word(OP_SPARE_LO, 8'hFF, 1'b1, 1'b1, 1'b0, 1'b1,
               levels(1'b1, 1'b1, 1'b1, 1'b0, 1'b0, 8'h00, 1'b0, 1'b0));
      add_word(OP_SPARE_HI, 8'hFF, 1'b1, 1'b1, 1'b0, 1'b1,
               levels(1'b1, 1'b1, 1'b1, 1'b0, 1'b0, 8'h00, 1'b0, 1'b0));
      // zero tick count runs as one, zero poll limit times out on the first high poll
      add_reg(i2cmbc_pkg::CSR_TICKS_PER_UNIT, 16'h0000);
      add_reg(i2cmbc_pkg::CSR_ACK_POLL_LIMIT, 16'h0000);
      add_reg(CSR_SPARE_LO, 16'hFFFF);
      add_reg(CSR_SPARE_HI, 16'hAAAA);
      add_word(i2cmbc_pkg::OP_WAIT_ACK, 8'h00, 1'b0, 1'b1, 1'b0);
      add_word(i2cmbc_pkg::OP_NONE, 8'h00, 1'b0, 1'b1, 1'b0);
      add_word(i2cmbc_pkg::OP_START, 8'h00, 1'b0, 1'b1, 1'b0, 1'b1,
               levels(1'b1, 1'b1, 1'b0, 1'b1, 1'b0, 8'h00, 1'b0, 1'b1));
      add_word(i2cmbc_pkg::OP_NONE, 8'h00, 1'b0, 1'b1, 1'b1);
      add_reg(i2cmbc_pkg::CSR_TICKS_PER_UNIT, 16'h0001);
      add_reg(i2cmbc_pkg::CSR_ACK_POLL_LIMIT, 16'h00FF);
      add_word(i2cmbc_pkg::OP_START, 8'h00, 1'b0, 1'b0, 1'b1);
      add_word(i2cmbc_pkg::OP_WRITE, 8'hFF, 1'b0, 1'b1, 1'b1);
      add_word(i2cmbc_pkg::OP_WAIT_ACK, 8'h00, 1'b0, 1'b0, 1'b1);
      add_word(i2cmbc_pkg::OP_WRITE, 8'h00, 1'b1, 1'b0, 1'b0);
      add_word(OP_SPARE_HI, 8'h5A, 1'b0, 1'b0, 1'b1);
      // no ack at the widest poll limit
      add_word(i2cmbc_pkg::OP_WAIT_ACK, 8'h00, 1'b0, 1'b1, 1'b1);
      add_word(i2cmbc_pkg::OP_READ, 8'h00, 1'b1, 1'b1, 1'b1);
      add_word(i2cmbc_pkg::OP_READ, 8'hFF, 1'b0, 1'b0, 1'b1);
      add_word(i2cmbc_pkg::OP_STOP, 8'h00, 1'b0, 1'b0, 1'b1);
      // upper data bits are dropped by the poll limit register
      add_reg(i2cmbc_pkg::CSR_ACK_POLL_LIMIT, 16'hFF02);
      add_word(i2cmbc_pkg::OP_WAIT_ACK, 8'hA5, 1'b1, 1'b1, 1'b1);

      repeat (3) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      foreach (probe_rows[i]) begin
         if (probe_rows[i].is_reg) begin
            write_reg(probe_rows[i].reg_idx, probe_rows[i].reg_data);
         end else begin
            send_word(probe_rows[i].op, probe_rows[i].tx, probe_rows[i].ack,
                      probe_rows[i].sda, probe_rows[i].typed, probe_rows[i].want);
            if (probe_rows[i].drain) drain_bus(1'b0, 1'b1, probe_rows[i].sda);
         end
      end

      run_phase(16'd1, 8'd3, 50, MIX_PLAIN);
      run_phase(16'd2, 8'd0, 50, MIX_PLAIN);
      run_phase(16'd1, 8'd255, 150, MIX_BACKPRESSURE);
      run_phase(16'd0, 8'd1, 50, MIX_STREAM);
      run_phase(16'd3, 8'd5, 50, MIX_PLAIN);

      // longest unit: the start stage loads the full delay width, words meanwhile rejected
      write_reg(i2cmbc_pkg::CSR_TICKS_PER_UNIT, 16'hFFFF);
      send_word(i2cmbc_pkg::OP_START, 8'($urandom), 1'($urandom_range(0, 1)),
                1'($urandom_range(0, 1)));
      repeat (30)
         send_word(3'($urandom_range(0, 7)), 8'($urandom), 1'($urandom_range(0, 1)),
                   1'($urandom_range(0, 1)));

      req_valid <= 1'b0;
      while (expected_q.size() != 0) @(negedge clock);
      repeat (10) @(negedge clock);
      if (mismatches == 0) begin
         $display("*** PASSED ***");
      end else begin
         $display("*** FAILED ***");
      end
      $finish;
   end

endmodule

// File: filelist.f
src/i2cmbc_pkg.sv
src/i2cmbc_seq.sv
src/i2c_master_byte_controller.sv
src/i2cmbc_checker.sv
tb/tb.sv
